// File: design/key_press_duration_classifier_top_assert.svh
// Assertion macros shared by the key press classifier RTL.
// Included by design files that carry concurrent checks; needs no package.
`ifndef KEY_PRESS_DURATION_CLASSIFIER_TOP_ASSERT_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpdc same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KPDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpdc next-cycle check failed");

`endif

// File: design/kpdc_pkg.sv
// Shared types, constants and helpers for the key press classifier.
// Used by kpdc_key_track and key_press_duration_classifier_top.
package kpdc_pkg;

    // Field widths and key count.
    localparam int KEY_COUNT   = 4;
    localparam int PIN_W       = 4;
    localparam int ACTIVE_KEYS = (KEY_COUNT < PIN_W) ? KEY_COUNT : PIN_W;
    localparam int TICK_W      = 16;
    localparam int LED_W       = 8;
    localparam int CFG_IDX_W   = 8;

    localparam logic [TICK_W-1:0] TICK_MAX          = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] SHORT_TICKS_RESET = TICK_W'(50);
    localparam logic [TICK_W-1:0] LONG_TICKS_RESET  = TICK_W'(800);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PRESS_TICKS = CFG_IDX_W'(0),
        CFG_LONG_PRESS_TICKS  = CFG_IDX_W'(1)
    } cfg_reg_idx_t;

    // Release classification reported by one key tracker.
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } key_event_t;

    // An LED pattern that shifts to zero restarts at the lowest LED.
    function automatic logic [LED_W-1:0] fix_zero(input logic [LED_W-1:0] v);
        fix_zero = (v == '0) ? LED_W'(1) : v;
    endfunction

endpackage

// File: design/kpdc_key_track.sv
// Per-key hold tracker: held flag, saturating hold count, release classifier.
// Depends on kpdc_pkg for widths and the key_event_t type.
module kpdc_key_track
    import kpdc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              pin,
    input  logic [TICK_W-1:0] short_ticks,
    input  logic [TICK_W-1:0] long_ticks,
    output key_event_t        key_event
);

    logic              held_reg;
    logic              held_next;
    logic [TICK_W-1:0] ticks_reg;
    logic [TICK_W-1:0] ticks_next;
    logic [TICK_W-1:0] ticks_inc;
    logic              pressed;

    assign pressed   = !pin;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + TICK_W'(1);

    // Hold bookkeeping and classification on release.
    always_comb begin
        held_next           = held_reg;
        ticks_next          = ticks_reg;
        key_event.short_evt = 1'b0;
        key_event.long_evt  = 1'b0;
        if (held_reg) begin
            ticks_next = ticks_inc;
            if (!pressed) begin
                if (ticks_inc >= long_ticks) begin
                    key_event.long_evt = 1'b1;
                end else if (ticks_inc >= short_ticks) begin
                    key_event.short_evt = 1'b1;
                end
                held_next  = 1'b0;
                ticks_next = '0;
            end
        end else if (pressed) begin
            held_next  = 1'b1;
            ticks_next = '0;
        end
    end

    // State advances only when a tick moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            ticks_reg <= '0;
        end else if (step_en) begin
            held_reg  <= held_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// File: design/key_press_duration_classifier_top.sv
// Top level of the short/long key press classifier with LED shift pattern.
// Depends on kpdc_pkg, kpdc_key_track and the assertion macro header.
//
// Usage: each request on the s_ channel is one millisecond tick with the raw
// pin levels of the keys (low means pressed). Every tick yields exactly one
// request on the m_ channel with the per-key short and long release pulses
// and the LED pattern after that tick.
// The cfg_ channel writes the short and long hold thresholds (index 0 and 1);
// other indexes are accepted and ignored. cfg_ready is always high; write it
// only while no tick is in flight.
// An accepted tick passes an input register and then a result register, and
// m_tvalid rises once the result register has loaded it.
// Throughput is one tick per cycle while m_tready stays high; the per-key
// update is a single saturating increment and two threshold compares between
// those registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) clears all key state and the LED pattern,
// empties both registers and restores thresholds 50 and 800.
module key_press_duration_classifier_top
    import kpdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Tick input.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [3:0] key_pins, [7:4] zero
    // Result output.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [3:0] short_press, [7:4] long_press,
                                            // [15:8] led_pattern
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    `include "key_press_duration_classifier_top_assert.svh"

    logic [TICK_W-1:0] short_ticks_reg;
    logic [TICK_W-1:0] long_ticks_reg;

    logic              in_valid_reg;
    logic [PIN_W-1:0]  pins_reg;
    logic              out_valid_reg;
    logic [PIN_W-1:0]  short_reg;
    logic [PIN_W-1:0]  long_reg;
    logic [LED_W-1:0]  led_reg;
    logic [LED_W-1:0]  led_next;
    logic [LED_W-1:0]  led_after_left;

    logic              out_free;
    logic              advance;
    logic [PIN_W-1:0]  shorts;
    logic [PIN_W-1:0]  longs;
    key_event_t        key_events [ACTIVE_KEYS];

    // Handshake: the result register frees when empty or taken.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {led_reg, long_reg, short_reg};

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_ticks_reg <= SHORT_TICKS_RESET;
            long_ticks_reg  <= LONG_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SHORT_PRESS_TICKS: short_ticks_reg <= cfg_data;
                CFG_LONG_PRESS_TICKS:  long_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= s_tdata[PIN_W-1:0];
        end
    end

    // One tracker per existing key; pins beyond them are ignored.
    for (genvar k = 0; k < ACTIVE_KEYS; k++) begin : g_key
        kpdc_key_track u_track (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step_en     (advance),
            .pin         (pins_reg[k]),
            .short_ticks (short_ticks_reg),
            .long_ticks  (long_ticks_reg),
            .key_event   (key_events[k])
        );
        assign shorts[k] = key_events[k].short_evt;
        assign longs[k]  = key_events[k].long_evt;
    end

    for (genvar k = ACTIVE_KEYS; k < PIN_W; k++) begin : g_absent
        assign shorts[k] = 1'b0;
        assign longs[k]  = 1'b0;
    end

    // LED pattern: a short press of key 0 shifts left first, then one of key 1 shifts right.
    always_comb begin
        led_after_left = shorts[0] ? fix_zero({led_reg[LED_W-2:0], 1'b0}) : led_reg;
        led_next       = shorts[1] ? fix_zero({1'b0, led_after_left[LED_W-1:1]})
                                   : led_after_left;
    end

    // Result register and LED state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            led_reg       <= '0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
            if (advance) begin
                led_reg <= led_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            short_reg <= shorts;
            long_reg  <= longs;
        end
    end

    // A key never reports both classes in one result.
    `KPDC_ASSERT_NOW(a_excl_class, aclk, aresetn, out_valid_reg, (short_reg & long_reg) == '0)
    // Once lit, the pattern never goes dark again.
    `KPDC_ASSERT_NEXT(a_led_stays_lit, aclk, aresetn, led_reg != '0, led_reg != '0)
    // Both registers full under a stall closes the input.
    `KPDC_ASSERT_NOW(a_full_stall, aclk, aresetn,
                     in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    // A result cannot appear without a tick in the input register.
    `KPDC_ASSERT_NEXT(a_no_phantom, aclk, aresetn,
                      !in_valid_reg && !out_valid_reg, !out_valid_reg)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for key_press_duration_classifier_top.
// Drives pin ticks and threshold writes, predicts every result in place and compares
// each field. Depends only on kpdc_pkg and the top level of the block.
module testbench;
    import kpdc_pkg::*;

    // Writes to this index must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = {CFG_IDX_W{1'b1}};
    localparam int IDLE_PCT       = 37;
    localparam int HOLD_OFF_TICKS = 300;
    localparam int SETTLE_CYCLES  = 4;

    // One result as the block reports it, highest bits first.
    typedef struct packed {
        logic [LED_W-1:0] led_bits;
        logic [PIN_W-1:0] long_hits;
        logic [PIN_W-1:0] short_hits;
    } tick_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;    // [3:0] key_pins, [7:4] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [3:0] short_press, [7:4] long_press,
                                           // [15:8] led_pattern
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data = '0;

    // Ticks waiting to be sent and results waiting to arrive.
    logic [PIN_W-1:0] tick_queue[$];
    tick_result_t     pending_results[$];
    int unsigned      error_count = 0;

    // Idle control: steady is shared by both sides, the hold-off is the receiver's.
    logic        steady = 1'b0;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // Predictor state.
    logic [TICK_W-1:0] short_thr = SHORT_TICKS_RESET;
    logic [TICK_W-1:0] long_thr  = LONG_TICKS_RESET;
    logic              key_held_q[PIN_W];
    logic [TICK_W-1:0] held_count[PIN_W];
    logic [LED_W-1:0]  lit_pattern = '0;

    // Stimulus generator state: current level of each key and ticks left at it.
    logic        gen_down[PIN_W];
    int unsigned gen_left[PIN_W];

    key_press_duration_classifier_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the key state by one tick and queue the result it must produce.
    function automatic void classify_tick(input logic [PIN_W-1:0] pins);
        tick_result_t     res;
        logic [LED_W-1:0] shifted;
        res = '0;
        for (int k = 0; k < ACTIVE_KEYS; k++) begin
            if (key_held_q[k]) begin
                if (held_count[k] != TICK_MAX) held_count[k] = held_count[k] + 1'b1;
                if (pins[k]) begin
                    // Long test first, so it wins when its threshold is lower.
                    if (held_count[k] >= long_thr) res.long_hits[k] = 1'b1;
                    else if (held_count[k] >= short_thr) res.short_hits[k] = 1'b1;
                    key_held_q[k] = 1'b0;
                    held_count[k] = '0;
                end
            end else if (!pins[k]) begin
                key_held_q[k] = 1'b1;
                held_count[k] = '0;
            end
        end
        // Key 0 shifts left, then key 1 shifts right; an empty pattern restarts at 1.
        if (res.short_hits[0]) begin
            shifted = lit_pattern << 1;
            lit_pattern = (shifted == '0) ? LED_W'(1) : shifted;
        end
        if (res.short_hits[1]) begin
            shifted = lit_pattern >> 1;
            lit_pattern = (shifted == '0) ? LED_W'(1) : shifted;
        end
        res.led_bits = lit_pattern;
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Sender: offer queued ticks, idling at random unless steady.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) classify_tick(s_tdata[PIN_W-1:0]);
            if (!s_tvalid || s_tready) begin
                if (tick_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, tick_queue.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result, stall at random or for a long hold-off.
    always @(posedge aclk) begin
        tick_result_t want;
        tick_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (got.short_hits !== want.short_hits)
                        report_mismatch($sformatf("short_press %h, want %h",
                                                  got.short_hits, want.short_hits));
                    if (got.long_hits !== want.long_hits)
                        report_mismatch($sformatf("long_press %h, want %h",
                                                  got.long_hits, want.long_hits));
                    if (got.led_bits !== want.led_bits)
                        report_mismatch($sformatf("led_pattern %h, want %h",
                                                  got.led_bits, want.led_bits));
                end
            end
            if (hold_go != hold_seen) begin
                hold_seen <= hold_go;
                hold_left <= HOLD_OFF_TICKS;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Hold length, often placed right at a threshold so both sides of it are hit.
    function automatic int unsigned hold_len();
        int unsigned target;
        case ($urandom_range(3))
            0: target = $urandom_range(1, 3);
            1: target = short_thr;
            2: target = long_thr;
            default: target = $urandom_range(1, 24);
        endcase
        if (target > 1500) target = $urandom_range(1, 24);
        target = target + $urandom_range(4);
        return (target > 2) ? target - 2 : 1;
    endfunction

    // Queue well-formed press and release sequences per key, with some noise ticks.
    task automatic push_presses(input int unsigned count);
        logic [PIN_W-1:0] pins;
        for (int unsigned n = 0; n < count; n++) begin
            for (int k = 0; k < PIN_W; k++) begin
                if (gen_left[k] == 0) begin
                    gen_down[k] = !gen_down[k];
                    gen_left[k] = gen_down[k] ? hold_len() : $urandom_range(1, 10);
                end
                gen_left[k]--;
                pins[k] = !gen_down[k];
            end
            if ($urandom_range(9) == 0) pins = PIN_W'($urandom_range(15));
            tick_queue.push_back(pins);
        end
    endtask

    task automatic push_run(input logic [PIN_W-1:0] pins, input int unsigned count);
        for (int unsigned n = 0; n < count; n++) tick_queue.push_back(pins);
    endtask

    // Wait until every tick is sent and every result has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SHORT_PRESS_TICKS) short_thr = val;
        else if (idx == CFG_LONG_PRESS_TICKS) long_thr = val;
    endtask

    task automatic set_thresholds(input logic [TICK_W-1:0] short_v,
                                  input logic [TICK_W-1:0] long_v);
        write_reg(CFG_SHORT_PRESS_TICKS, short_v);
        write_reg(CFG_LONG_PRESS_TICKS, long_v);
    endtask

    // Test sequence.
    initial begin
        for (int k = 0; k < PIN_W; k++) begin
            key_held_q[k] = 1'b0;
            held_count[k] = '0;
            gen_down[k]   = 1'b0;
            gen_left[k]   = 1;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset thresholds, with neither side idling.
        @(negedge aclk);
        steady = 1'b1;
        push_presses(700);
        wait_drained();
        steady = 1'b0;

        // Directed: release one tick short, exactly at short, exactly at long,
        // all keys at once, and single keys shifting the pattern both ways.
        set_thresholds(16'd2, 16'd5);
        @(negedge aclk);
        push_run(4'hF, 1);
        push_run(4'h0, 1);
        push_run(4'hF, 1);
        push_run(4'h0, 2);
        push_run(4'hF, 1);
        push_run(4'h0, 5);
        push_run(4'hF, 1);
        push_run(4'hE, 3);
        push_run(4'hF, 1);
        push_run(4'hD, 3);
        push_run(4'hF, 1);
        push_run(4'hC, 3);
        push_run(4'h3, 1);
        push_run(4'hF, 1);
        wait_drained();

        // Long threshold below the short one; writes to two unused indexes.
        set_thresholds(16'd5, 16'd3);
        write_reg(CFG_IDX_SPARE, 16'd0);
        write_reg(CFG_IDX_TOP, 16'hFFFF);
        @(negedge aclk);
        push_presses(200);
        wait_drained();

        // Zero short threshold: every hold is an event.
        set_thresholds(16'd0, 16'hFFFF);
        @(negedge aclk);
        push_presses(200);
        wait_drained();

        // The receiver holds off while ticks keep coming, so the input stalls.
        set_thresholds(16'd1, 16'd3);
        @(negedge aclk);
        hold_go = !hold_go;
        push_presses(200);
        wait_drained();

        // Zero long threshold: every hold is long.
        set_thresholds(16'd0, 16'd0);
        @(negedge aclk);
        push_presses(100);
        wait_drained();

        // Random small thresholds.
        for (int p = 0; p < 4; p++) begin
            set_thresholds(TICK_W'($urandom_range(0, 12)), TICK_W'($urandom_range(0, 16)));
            @(negedge aclk);
            push_presses(50);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #12000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/kpdc_pkg.sv
design/kpdc_key_track.sv
design/key_press_duration_classifier_top.sv
tb/testbench.sv
